FILE: rtl/tpe_pkg.sv
`default_nettype none

package tpe_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned OFFSET_W    = 16;
    localparam int unsigned HDR_W       = 6;
    localparam int unsigned SUM_W       = HDR_W + 1;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0]          IHL_MASK    = 4'd15;
    localparam logic [SUM_W-1:0]    TCP_OFF_POS = SUM_W'(12);
    localparam logic [SUM_W-1:0]    MIN_HDR     = SUM_W'(20);
    localparam logic [OFFSET_W-1:0] OFF_VER     = OFFSET_W'(0);
    localparam logic [OFFSET_W-1:0] OFF_LEN_HI  = OFFSET_W'(2);
    localparam logic [OFFSET_W-1:0] OFF_LEN_LO  = OFFSET_W'(3);

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_last;
        logic              header_error;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ipv4_tcp_payload_extractor.sv
// Channel   Handshake         Accepted when        Word
// input     i_push / o_full   i_push && !o_full    i_stream_byte
// result    o_empty / i_pop   i_pop && !o_empty    o_payload_byte, o_payload_last, o_header_error
//
// One stream byte is taken every cycle while the result queue has room.
// The parser settles each byte in the cycle it is taken; any result word is
// registered into the result queue and reaches the result ports once older words are popped.
// The four-entry result queue lets the consumer stall without stopping input
// until it fills. Reset is synchronous, active low, and empties the queue.
`default_nettype none

module ipv4_tcp_payload_extractor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_stream_byte,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_payload_byte,
    output logic            o_payload_last,
    output logic            o_header_error
);
    import tpe_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result head;

    assign accept = i_push && !o_full;

    tpe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_stream_byte  (i_stream_byte),
        .o_result       (res),
        .o_result_valid (res_valid)
    );

    tpe_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_valid),
        .i_wr_data (res),
        .i_rd_en   (i_pop),
        .o_rd_data (head),
        .o_empty   (o_empty),
        .o_full    (o_full)
    );

    assign o_payload_byte = head.payload_byte;
    assign o_payload_last = head.payload_last;
    assign o_header_error = head.header_error;

endmodule

`default_nettype wire

FILE: rtl/tpe_front.sv
`default_nettype none

module tpe_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_stream_byte,
    output tpe_pkg::t_result          o_result,
    output logic                      o_result_valid
);
    import tpe_pkg::*;

    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [OFFSET_W-1:0] r_total, n_total;
    logic [HDR_W-1:0]    r_ip_hdr, n_ip_hdr;
    logic [HDR_W-1:0]    r_tcp_hdr, n_tcp_hdr;
    logic                r_skipping, n_skipping;

    logic [OFFSET_W:0]   offset_inc;
    logic [SUM_W-1:0]    ip_sum_min;
    logic [SUM_W-1:0]    ip_tcp_pos;
    logic [SUM_W-1:0]    hdr_sum;
    logic [HDR_W-1:0]    tcp_new;
    logic [SUM_W-1:0]    ip_tcp_new;

    assign offset_inc = {1'b0, r_offset} + 17'd1;
    assign ip_sum_min = {1'b0, r_ip_hdr} + MIN_HDR;
    assign ip_tcp_pos = {1'b0, r_ip_hdr} + TCP_OFF_POS;
    assign hdr_sum    = {1'b0, r_ip_hdr} + {1'b0, r_tcp_hdr};
    assign tcp_new    = {i_stream_byte[7:4], 2'b00};
    assign ip_tcp_new = {1'b0, r_ip_hdr} + {1'b0, tcp_new};

    always_comb begin
        n_offset       = r_offset;
        n_total        = r_total;
        n_ip_hdr       = r_ip_hdr;
        n_tcp_hdr      = r_tcp_hdr;
        n_skipping     = r_skipping;
        o_result_valid = 1'b0;
        o_result       = '0;
        if (i_accept) begin
            if (r_offset == OFF_VER) begin
                n_ip_hdr   = {i_stream_byte[3:0] & IHL_MASK, 2'b00};
                n_tcp_hdr  = '0;
                n_total    = '0;
                n_skipping = 1'b0;
            end else if (r_offset == OFF_LEN_HI) begin
                n_total = {i_stream_byte, 8'h00};
            end else if (r_offset == OFF_LEN_LO) begin
                n_total = {r_total[15:8], i_stream_byte};
                if (({1'b0, r_ip_hdr} < MIN_HDR) ||
                    (n_total < OFFSET_W'(ip_sum_min))) begin
                    o_result_valid      = 1'b1;
                    o_result.header_error = 1'b1;
                    n_skipping          = 1'b1;
                end
            end else if (!r_skipping) begin
                if (r_tcp_hdr == '0) begin
                    if (r_offset == OFFSET_W'(ip_tcp_pos)) begin
                        n_tcp_hdr = tcp_new;
                        if (({1'b0, tcp_new} < MIN_HDR) ||
                            (r_total < OFFSET_W'(ip_tcp_new))) begin
                            o_result_valid        = 1'b1;
                            o_result.header_error = 1'b1;
                            n_skipping            = 1'b1;
                        end
                    end
                end else if ((r_offset >= OFFSET_W'(hdr_sum)) && (r_offset < r_total)) begin
                    o_result_valid        = 1'b1;
                    o_result.payload_byte = i_stream_byte;
                    o_result.payload_last = (offset_inc == {1'b0, r_total});
                end
            end
            if ((r_offset >= OFF_LEN_LO) && (offset_inc >= {1'b0, n_total})) begin
                n_offset = '0;
            end else begin
                n_offset = offset_inc[OFFSET_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_total    <= '0;
            r_ip_hdr   <= '0;
            r_tcp_hdr  <= '0;
            r_skipping <= 1'b0;
        end else begin
            r_offset   <= n_offset;
            r_total    <= n_total;
            r_ip_hdr   <= n_ip_hdr;
            r_tcp_hdr  <= n_tcp_hdr;
            r_skipping <= n_skipping;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tpe_queue.sv
`default_nettype none

module tpe_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire tpe_pkg::t_result     i_wr_data,
    input  wire logic                 i_rd_en,
    output tpe_pkg::t_result          o_rd_data,
    output logic                      o_empty,
    output logic                      o_full
);
    import tpe_pkg::*;

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0]  r_count, n_count;
    logic                do_wr;
    logic                do_rd;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + FIFO_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + FIFO_CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tpe_checker.sv
`default_nettype none

module tpe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_push,
    input wire logic       o_full,
    input wire logic [7:0] i_stream_byte,
    input wire logic       i_pop,
    input wire logic       o_empty,
    input wire logic [7:0] o_payload_byte,
    input wire logic       o_payload_last,
    input wire logic       o_header_error
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue not empty after reset");

    a_error_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_header_error) |-> (o_payload_byte == 8'd0 && !o_payload_last))
        else $error("error word carries payload data");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("queue both full and empty");

    a_pop_frees_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !(i_push && !o_full)) |=> !o_full)
        else $error("queue full after a pop without a push");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_payload_byte)
            && $stable(o_payload_last) && $stable(o_header_error)))
        else $error("waiting result word changed");

endmodule

bind ipv4_tcp_payload_extractor tpe_checker u_tpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_push         (i_push),
    .o_full         (o_full),
    .i_stream_byte  (i_stream_byte),
    .i_pop          (i_pop),
    .o_empty        (o_empty),
    .o_payload_byte (o_payload_byte),
    .o_payload_last (o_payload_last),
    .o_header_error (o_header_error)
);

`default_nettype wire

FILE: sim/tpe_result_checker.sv
`timescale 1ns / 100ps

module tpe_result_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic       i_full,
    input  wire logic [7:0] i_stream_byte,
    input  wire logic       i_pop,
    input  wire logic       i_empty,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_payload_last,
    input  wire logic       i_header_error,
    output int              o_fail_count,
    output int              o_pending
);
    import tpe_pkg::*;

    logic [OFFSET_W-1:0] pkt_offset;
    logic [OFFSET_W-1:0] pkt_total;
    logic [HDR_W-1:0]    ip_len;
    logic [HDR_W-1:0]    tcp_len;
    logic                discarding;
    t_result             expected_words[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic parse_stream_byte(input logic [7:0] b);
        int      off;
        int      hdr_sum;
        logic    produced;
        t_result w;
        off      = int'(pkt_offset);
        produced = 1'b0;
        w        = '0;
        if (pkt_offset == OFF_VER) begin
            ip_len     = {b[3:0] & IHL_MASK, 2'b00};
            tcp_len    = '0;
            pkt_total  = '0;
            discarding = 1'b0;
        end else if (pkt_offset == OFF_LEN_HI) begin
            pkt_total = {b, 8'h00};
        end else if (pkt_offset == OFF_LEN_LO) begin
            pkt_total[7:0] = b;
            if (int'(ip_len) < int'(MIN_HDR) ||
                int'(pkt_total) < int'(ip_len) + int'(MIN_HDR)) begin
                w.header_error = 1'b1;
                produced       = 1'b1;
                discarding     = 1'b1;
            end
        end else if (!discarding) begin
            if (tcp_len == '0) begin
                if (off == int'(ip_len) + int'(TCP_OFF_POS)) begin
                    tcp_len = {b[7:4], 2'b00};
                    if (int'(tcp_len) < int'(MIN_HDR) ||
                        int'(pkt_total) < int'(ip_len) + int'(tcp_len)) begin
                        w.header_error = 1'b1;
                        produced       = 1'b1;
                        discarding     = 1'b1;
                    end
                end
            end else begin
                hdr_sum = int'(ip_len) + int'(tcp_len);
                if (off >= hdr_sum && off < int'(pkt_total)) begin
                    w.payload_byte = b;
                    w.payload_last = (off + 1 == int'(pkt_total));
                    produced       = 1'b1;
                end
            end
        end
        if (off >= 3 && off + 1 >= int'(pkt_total)) begin
            pkt_offset = '0;
        end else begin
            pkt_offset = pkt_offset + 1'b1;
        end
        if (produced) begin
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        t_result w;
        if (expected_words.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: unexpected word byte %h last %b err %b", $realtime,
                         i_payload_byte, i_payload_last, i_header_error);
            end
        end else begin
            w = expected_words.pop_front();
            if (w.payload_byte !== i_payload_byte || w.payload_last !== i_payload_last ||
                w.header_error !== i_header_error) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("%0t: expected byte %h last %b err %b, got byte %h last %b err %b",
                             $realtime, w.payload_byte, w.payload_last, w.header_error,
                             i_payload_byte, i_payload_last, i_header_error);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_offset = '0;
            pkt_total  = '0;
            ip_len     = '0;
            tcp_len    = '0;
            discarding = 1'b0;
            expected_words.delete();
        end else begin
            if (i_push && !i_full) begin
                parse_stream_byte(i_stream_byte);
            end
            if (i_pop && !i_empty) begin
                check_word();
            end
        end
        o_pending = expected_words.size();
    end

endmodule

FILE: sim/tb_ipv4_tcp_payload_extractor.sv
`timescale 1ns / 100ps

module tb_ipv4_tcp_payload_extractor;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 100;
    localparam int LONG_HOLD    = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_stream_byte;
    logic       i_pop;
    logic       o_empty;
    logic [7:0] o_payload_byte;
    logic       o_payload_last;
    logic       o_header_error;
    int         fail_count;
    int         pending;
    int         cycles;
    int         random_bytes;

    ipv4_tcp_payload_extractor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_stream_byte  (i_stream_byte),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_payload_byte (o_payload_byte),
        .o_payload_last (o_payload_last),
        .o_header_error (o_header_error)
    );

    tpe_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_stream_byte  (i_stream_byte),
        .i_pop          (i_pop),
        .i_empty        (o_empty),
        .i_payload_byte (o_payload_byte),
        .i_payload_last (o_payload_last),
        .i_header_error (o_header_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_pop         = 1'b0;
        i_stream_byte = '0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push        <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [3:0] ihl, input logic [15:0] total,
                               input logic [3:0] doff);
        int          count;
        int          doff_pos;
        logic [7:0]  b;
        count    = (total <= 16'd4) ? 4 : int'(total);
        doff_pos = 4 * int'(ihl) + 12;
        for (int i = 0; i < count; i++) begin
            b = 8'($urandom());
            if (i == 0) begin
                b[3:0] = ihl;
            end else if (i == 2) begin
                b = total[15:8];
            end else if (i == 3) begin
                b = total[7:0];
            end else if (i == doff_pos) begin
                b[7:4] = doff;
            end
            send_byte(b);
        end
        random_bytes += count;
    endtask

    task automatic send_random_packet();
        int         r;
        int         hdr;
        logic [3:0] ihl;
        logic [3:0] doff;
        int         pay;
        r    = $urandom_range(0, 99);
        ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        hdr  = 4 * int'(ihl);
        if (r < 72) begin
            send_packet(ihl, 16'(hdr + 4 * int'(doff) + pay), doff);
        end else if (r < 77) begin
            send_packet(4'($urandom_range(0, 4)), 16'($urandom_range(0, 60)), doff);
        end else if (r < 82) begin
            send_packet(ihl, 16'($urandom_range(0, hdr + 19)), doff);
        end else if (r < 87) begin
            send_packet(ihl, 16'(hdr + 20 + pay), 4'($urandom_range(0, 4)));
        end else if (r < 92) begin
            doff = 4'($urandom_range(6, 15));
            send_packet(ihl, 16'($urandom_range(hdr + 20, hdr + 4 * int'(doff) - 1)), doff);
        end else begin
            send_packet(4'($urandom()), 16'($urandom_range(0, 90)), 4'($urandom()));
        end
    endtask

    initial begin
        int  gap;
        int  pops;
        bit  held;
        pops = 0;
        held = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (!held && pops >= 40) begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            pops++;
            @(negedge i_clk);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        random_bytes = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_packet(4'd5, 16'd100, 4'd5);
        send_packet(4'd5, 16'd40, 4'd5);
        send_packet(4'd4, 16'd24, 4'd5);
        send_packet(4'd0, 16'd0, 4'd0);
        send_packet(4'd5, 16'd4, 4'd5);
        send_packet(4'd5, 16'd39, 4'd5);
        send_packet(4'd5, 16'd40, 4'd4);
        send_packet(4'd5, 16'd50, 4'd10);

        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            send_random_packet();
        end
        i_push <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
